// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
// Expands to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RSPW_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`define RSPW_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RSPW_ASSERT(lbl, clk, rstn, prop)
`define RSPW_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- rtl/rspw_pkg.sv -----
// Shared types and constants of the run-length sprite expander.
// No dependencies.
package rspw_pkg;

  localparam int COUNT_WIDTH_DEF = 18;
  localparam int QUEUE_DEPTH     = 2;
  localparam int PIX_PER_WORD    = 8;

  localparam logic [5:0]  EVEN_COLOUR_BITS = 6'b111000;
  localparam logic [5:0]  ODD_COLOUR_BITS  = 6'b000111;
  localparam logic [17:0] IMAGE_PIXELS_RST = 18'd153600;

  typedef enum logic [1:0] {
    CFG_PIXEL_COLOUR   = 2'd0,
    CFG_OVERWRITE_MODE = 2'd1,
    CFG_IMAGE_PIXELS   = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [5:0]  pixel_colour;
    logic        overwrite_mode;
    logic [17:0] image_pixels;
  } cfg_t;

  typedef struct packed {
    logic [7:0] run_length;
    logic       is_zero;
  } run_item_t;

  typedef enum logic {
    BK_LOAD,
    BK_EXPAND
  } bk_state_t;

  typedef struct packed {
    logic busy;
    logic run_on;
  } bk_status_t;

endpackage

// ----- rtl/rle_sprite_to_pixel_pair_words.sv -----
// Run-length sprite expander: off/on runs in, words of eight 3-bit pixels out.
// A run of L pixels leaves the run queue in the load state; the expander then
// builds one partial word per cycle, unless the output register is held, for
// each of about ceil((fill + L) / 8) words it touches; a zero run only flips
// polarity. A two-entry run queue keeps taking input while words drain, and
// an output register holds one finished word. Depends on rspw_pkg, rspw_front,
// rspw_back and assert_macros.svh.
`include "assert_macros.svh"
module rle_sprite_to_pixel_pair_words #(
  parameter int COUNT_WIDTH = rspw_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [17:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_run_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_pixel_word,
  output logic [7:0]  out_keep_mask,
  output logic        out_last_word
);

  rspw_pkg::cfg_t       cfg_r;
  rspw_pkg::run_item_t  q_item;
  rspw_pkg::bk_status_t bk_status;
  logic                 q_valid, q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pixel_colour   <= '0;
      cfg_r.overwrite_mode <= 1'b0;
      cfg_r.image_pixels   <= rspw_pkg::IMAGE_PIXELS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rspw_pkg::CFG_PIXEL_COLOUR:   cfg_r.pixel_colour   <= cfg_wdata[5:0];
        rspw_pkg::CFG_OVERWRITE_MODE: cfg_r.overwrite_mode <= cfg_wdata[0];
        rspw_pkg::CFG_IMAGE_PIXELS:   cfg_r.image_pixels   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  rspw_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_run_length (in_run_length),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_item        (q_item)
  );

  rspw_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_valid        (q_valid),
    .q_ready        (q_ready),
    .q_item         (q_item),
    .status         (bk_status),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_word (out_pixel_word),
    .out_keep_mask  (out_keep_mask),
    .out_last_word  (out_last_word)
  );

  // a transfer into the queue leaves it non-empty
  `RSPW_ASSERT_NEXT(a_push_fills, clk, rst_n, in_valid && in_ready, q_valid)
  // a zero run only flips polarity and never starts expansion
  `RSPW_ASSERT_NEXT(a_zero_toggles, clk, rst_n, q_valid && q_ready && q_item.is_zero, (!bk_status.busy) && (bk_status.run_on != $past(bk_status.run_on)))
  // a nonzero run always starts expansion
  `RSPW_ASSERT_NEXT(a_run_starts, clk, rst_n, q_valid && q_ready && !q_item.is_zero, bk_status.busy)
  // the queue is only drained while the expander is free
  `RSPW_ASSERT(a_pop_idle, clk, rst_n, !(q_ready && bk_status.busy))

endmodule

// ----- rtl/rspw_front.sv -----
// Front end: accepts run lengths, flags zero runs, queues them.
// Depends on rspw_pkg.
module rspw_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_run_length,
  output logic                 q_valid,
  input  logic                 q_ready,
  output rspw_pkg::run_item_t  q_item
);

  localparam int PW = (rspw_pkg::QUEUE_DEPTH > 1) ? $clog2(rspw_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(rspw_pkg::QUEUE_DEPTH + 1);

  rspw_pkg::run_item_t mem_r [rspw_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic push, pop;

  assign in_ready = (count_r != CW'(rspw_pkg::QUEUE_DEPTH));
  assign q_valid  = (count_r != '0);
  assign q_item   = mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(rspw_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= '{run_length: in_run_length, is_zero: (in_run_length == 8'd0)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop)      count_r <= count_r + CW'(1);
      else if (pop && !push) count_r <= count_r - CW'(1);
    end
  end

endmodule

// ----- rtl/rspw_back.sv -----
// Back end: expands runs into pixel words, one chunk a cycle unless stalled.
// Depends on rspw_pkg.
module rspw_back #(
  parameter int COUNT_WIDTH = rspw_pkg::COUNT_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rspw_pkg::cfg_t       cfg,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  rspw_pkg::run_item_t  q_item,
  output rspw_pkg::bk_status_t status,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [31:0]          out_pixel_word,
  output logic [7:0]           out_keep_mask,
  output logic                 out_last_word
);

  rspw_pkg::bk_state_t state_r, state_nxt;
  logic                   run_on_r, run_on_nxt;
  logic [COUNT_WIDTH-1:0] done_r, done_nxt;
  logic [7:0]             rem_r, rem_nxt;
  logic [31:0]            word_r, word_nxt;
  logic [7:0]             keep_r, keep_nxt;
  logic [2:0]             fill_r, fill_nxt;
  logic                   ov_r, ov_nxt;
  logic [31:0]            ow_r;
  logic [7:0]             ok_r;
  logic                   ol_r;

  logic [COUNT_WIDTH-1:0] total, to_end;
  logic [3:0]             room, n0, n, fill_sum;
  logic                   near_end, ends, emit, stall, load_out;
  logic [7:0]             sel;
  logic [31:0]            col_word, word_new;
  logic [7:0]             keep_new;
  logic [5:0]             ce, co;

  assign total    = COUNT_WIDTH'(cfg.image_pixels);
  assign to_end   = total - done_r;
  assign near_end = (to_end != '0) && (to_end <= COUNT_WIDTH'(rspw_pkg::PIX_PER_WORD));
  assign room     = 4'(rspw_pkg::PIX_PER_WORD) - {1'b0, fill_r};
  assign n0       = (rem_r < {4'd0, room}) ? rem_r[3:0] : room;
  assign ends     = near_end && (to_end[3:0] <= n0);
  assign n        = ends ? to_end[3:0] : n0;
  assign fill_sum = {1'b0, fill_r} + n;
  assign emit     = fill_sum[3] || ends;
  assign ce       = cfg.pixel_colour & rspw_pkg::EVEN_COLOUR_BITS;
  assign co       = cfg.pixel_colour & rspw_pkg::ODD_COLOUR_BITS;

  always_comb begin
    sel      = '0;
    col_word = '0;
    for (int s = 0; s < rspw_pkg::PIX_PER_WORD; s++) begin
      sel[s] = (4'(s) >= {1'b0, fill_r}) && (4'(s) < fill_sum);
      if (s % 2 == 0) col_word[8*(s>>1)+3 +: 3] = sel[s] ? ce[5:3] : 3'd0;
      else            col_word[8*(s>>1)   +: 3] = sel[s] ? co[2:0] : 3'd0;
    end
  end

  assign word_new = word_r | (run_on_r ? col_word : 32'd0);
  assign keep_new = keep_r | ((!run_on_r && !cfg.overwrite_mode) ? sel : 8'd0);
  assign stall    = emit && ov_r && !out_ready;

  always_comb begin
    state_nxt  = state_r;
    run_on_nxt = run_on_r;
    done_nxt   = done_r;
    rem_nxt    = rem_r;
    word_nxt   = word_r;
    keep_nxt   = keep_r;
    fill_nxt   = fill_r;
    q_ready    = 1'b0;
    load_out   = 1'b0;
    unique case (state_r)
      rspw_pkg::BK_LOAD: begin
        q_ready = 1'b1;
        if (q_valid) begin
          if (q_item.is_zero) begin
            run_on_nxt = !run_on_r;
          end else begin
            rem_nxt   = q_item.run_length;
            state_nxt = rspw_pkg::BK_EXPAND;
          end
        end
      end
      rspw_pkg::BK_EXPAND: begin
        if (!stall) begin
          load_out = emit;
          rem_nxt  = rem_r - {4'd0, n};
          if (emit) begin
            word_nxt = '0;
            keep_nxt = '0;
            fill_nxt = '0;
          end else begin
            word_nxt = word_new;
            keep_nxt = keep_new;
            fill_nxt = fill_sum[2:0];
          end
          if (ends) begin
            done_nxt   = '0;
            run_on_nxt = 1'b0;
            state_nxt  = rspw_pkg::BK_LOAD;
          end else begin
            done_nxt = done_r + COUNT_WIDTH'(n);
            if (rem_nxt == 8'd0) begin
              run_on_nxt = !run_on_r;
              state_nxt  = rspw_pkg::BK_LOAD;
            end
          end
        end
      end
      default: state_nxt = rspw_pkg::BK_LOAD;
    endcase
    ov_nxt = load_out ? 1'b1 : (out_ready ? 1'b0 : ov_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= rspw_pkg::BK_LOAD;
      run_on_r <= 1'b0;
      done_r   <= '0;
      word_r   <= '0;
      keep_r   <= '0;
      fill_r   <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      run_on_r <= run_on_nxt;
      done_r   <= done_nxt;
      word_r   <= word_nxt;
      keep_r   <= keep_nxt;
      fill_r   <= fill_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    if (load_out) begin
      ow_r <= word_new;
      ok_r <= keep_new;
      ol_r <= ends;
    end
  end

  assign status         = '{busy: (state_r == rspw_pkg::BK_EXPAND), run_on: run_on_r};
  assign out_valid      = ov_r;
  assign out_pixel_word = ow_r;
  assign out_keep_mask  = ok_r;
  assign out_last_word  = ol_r;

endmodule
